FILE: rtl/tzs_pkg.sv
// types, constants and helper functions shared by the triangle z slice unit
package tzs_pkg;

  localparam int CW       = 32;             // coordinate width, signed Q16.16
  localparam int MW       = CW + 1;         // magnitude of a coordinate difference
  localparam int PW       = 2 * MW;         // full product width
  localparam int QB       = MW;             // quotient bits
  localparam int BPS      = 3;              // quotient bits resolved per divider stage
  localparam int NDS      = (QB + BPS - 1) / BPS;
  localparam int NLANE    = 4;              // start x, start y, end x, end y
  localparam int NST      = 3 + NDS + 1;    // pipeline stages with a valid bit
  localparam int IN_W     = 9 * CW;
  localparam int OUT_W    = ((1 + 6 * CW + 7) / 8) * 8;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [MW-1:0]        mag_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vtx_t;

  // crossing edge, from the vertex above the plane to the one below
  typedef struct packed {
    vtx_t a;
    vtx_t b;
  } edge_t;

  typedef struct packed {
    logic            sliced;
    coord_t          cut;
    edge_t [1:0]     e;
  } cls_t;

  typedef struct packed {
    coord_t a;
    logic   neg;
    mag_t   md;
    mag_t   nm;
    mag_t   dm;
  } lerp_t;

  typedef struct packed {
    logic               sliced;
    coord_t             cut;
    lerp_t [NLANE-1:0]  ln;
  } diff_t;

  typedef struct packed {
    coord_t a;
    logic   neg;
    mag_t   dm;
    mag_t   rem;
    mag_t   low;
    mag_t   q;
  } lane_t;

  typedef struct packed {
    logic               sliced;
    coord_t             cut;
    lane_t [NLANE-1:0]  ln;
  } div_t;

  // restoring division, BPS quotient bits
  function automatic lane_t div_steps(input lane_t li);
    lane_t       lo;
    logic [MW:0] r;
    lo = li;
    for (int s = 0; s < BPS; s++) begin
      r      = {lo.rem, lo.low[MW-1]};
      lo.low = {lo.low[MW-2:0], 1'b0};
      if (r >= {1'b0, lo.dm}) begin
        r    = r - {1'b0, lo.dm};
        lo.q = {lo.q[MW-2:0], 1'b1};
      end else begin
        lo.q = {lo.q[MW-2:0], 1'b0};
      end
      lo.rem = r[MW-1:0];
    end
    return lo;
  endfunction

  // set up one interpolation lane: a + round((b - a) * nm / dm)
  function automatic lerp_t mk_lerp(input coord_t a, input coord_t b,
                                    input mag_t nm, input mag_t dm);
    lerp_t       l;
    logic [MW-1:0] d;
    d     = MW'(b) - MW'(a);
    l.a   = a;
    l.neg = d[MW-1];
    l.md  = d[MW-1] ? (~d + MW'(1)) : d;
    l.nm  = nm;
    l.dm  = dm;
    return l;
  endfunction

endpackage

FILE: rtl/triangle_z_slice_unit.sv
// top level: pipelined slicing of one triangle by the plane z = cut height
//
//  channel   dir  bits  content
//  s_axis    in   288   vertex a x,y,z ; vertex b x,y,z ; vertex c x,y,z
//  m_axis    out  200   sliced ; start x,y,z ; end x,y,z ; zero pad
//  cut cfg   in   32    cut height, written when we is high
//
// one item per cycle while m_axis_tready_i is high; 15 register stages
// the depth is set by the 11 divider stages, 3 quotient bits each
// a full stage holds while its successor is full and stalled, so bubbles close up
// reset clears all valid bits and the cut height to zero
module triangle_z_slice_unit
  import tzs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // sliced, start_x, start_y, start_z, end_x, end_y, end_z, zero pad from bit 0 up
  output logic [OUT_W-1:0] m_axis_tdata_o,
  input  logic             cut_height_we_i,
  input  logic [CW-1:0]    cut_height_i
);

  coord_t            cut_q;
  logic [NST-1:0]    v_q;
  logic [NST:0]      en;
  cls_t              cls_q, cls_d;
  diff_t             dif_q, dif_d;
  div_t              dv_q [NDS+1];
  div_t              dv0_d;
  logic [OUT_W-1:0]  out_q, out_d;
  vtx_t [2:0]        vin;
  logic [2:0]        below;
  logic              lt_any, gt_any;

  // cut height register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_q <= '0;
    end else if (cut_height_we_i) begin
      cut_q <= coord_t'(cut_height_i);
    end
  end

  // handshake chain: a stage moves when it is empty or its successor moves
  always_comb begin
    en[NST] = m_axis_tready_i;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end
  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = v_q[NST-1];
  assign m_axis_tdata_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 1: classify vertices against the plane and pick the two crossing edges
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vin[i].x = coord_t'(s_axis_tdata_i[(3*i+0)*CW +: CW]);
      vin[i].y = coord_t'(s_axis_tdata_i[(3*i+1)*CW +: CW]);
      vin[i].z = coord_t'(s_axis_tdata_i[(3*i+2)*CW +: CW]);
      below[i] = vin[i].z <= cut_q;
    end
    lt_any = (vin[0].z < cut_q) || (vin[1].z < cut_q) || (vin[2].z < cut_q);
    gt_any = !below[0] || !below[1] || !below[2];
    cls_d.sliced = lt_any && gt_any;
    cls_d.cut    = cut_q;
    // below mask is {c, b, a}
    case (below)
      3'b011: begin cls_d.e[0] = {vin[2], vin[0]}; cls_d.e[1] = {vin[2], vin[1]}; end
      3'b101: begin cls_d.e[0] = {vin[1], vin[0]}; cls_d.e[1] = {vin[1], vin[2]}; end
      3'b110: begin cls_d.e[0] = {vin[0], vin[1]}; cls_d.e[1] = {vin[0], vin[2]}; end
      3'b001: begin cls_d.e[0] = {vin[1], vin[0]}; cls_d.e[1] = {vin[2], vin[0]}; end
      3'b010: begin cls_d.e[0] = {vin[0], vin[1]}; cls_d.e[1] = {vin[2], vin[1]}; end
      3'b100: begin cls_d.e[0] = {vin[0], vin[2]}; cls_d.e[1] = {vin[1], vin[2]}; end
      // all on one side: no slice, edges are don't care
      default: begin cls_d.e[0] = {vin[0], vin[1]}; cls_d.e[1] = {vin[0], vin[2]}; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) cls_q <= cls_d;
  end

  // stage 2: edge deltas, the t numerator and denominator per lane
  always_comb begin
    mag_t nm [2];
    mag_t dm [2];
    for (int j = 0; j < 2; j++) begin
      nm[j] = MW'(cls_q.e[j].a.z) - MW'(cls_q.cut);
      dm[j] = MW'(cls_q.e[j].a.z) - MW'(cls_q.e[j].b.z);
    end
    dif_d.sliced = cls_q.sliced;
    dif_d.cut    = cls_q.cut;
    for (int j = 0; j < 2; j++) begin
      dif_d.ln[2*j]   = mk_lerp(cls_q.e[j].a.x, cls_q.e[j].b.x, nm[j], dm[j]);
      dif_d.ln[2*j+1] = mk_lerp(cls_q.e[j].a.y, cls_q.e[j].b.y, nm[j], dm[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) dif_q <= dif_d;
  end

  // stage 3: full product |b - a| * nm, loaded into the divider
  always_comb begin
    logic [PW-1:0] p;
    dv0_d.sliced = dif_q.sliced;
    dv0_d.cut    = dif_q.cut;
    for (int l = 0; l < NLANE; l++) begin
      p = PW'(dif_q.ln[l].md) * PW'(dif_q.ln[l].nm);
      dv0_d.ln[l].a   = dif_q.ln[l].a;
      dv0_d.ln[l].neg = dif_q.ln[l].neg;
      dv0_d.ln[l].dm  = dif_q.ln[l].dm;
      dv0_d.ln[l].rem = p[PW-1:MW];
      dv0_d.ln[l].low = p[MW-1:0];
      dv0_d.ln[l].q   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) dv_q[0] <= dv0_d;
  end

  // divider stages
  for (genvar g = 1; g <= NDS; g++) begin : g_div
    div_t nx;
    always_comb begin
      nx.sliced = dv_q[g-1].sliced;
      nx.cut    = dv_q[g-1].cut;
      for (int l = 0; l < NLANE; l++) begin
        nx.ln[l] = div_steps(dv_q[g-1].ln[l]);
      end
    end
    always_ff @(posedge clk_i) begin
      if (en[2+g]) dv_q[g] <= nx;
    end
  end

  // last stage: round half away from zero, apply sign, pack the result
  always_comb begin
    coord_t       res [NLANE];
    logic [MW:0]  twice;
    mag_t         qr;
    lane_t        ln;
    for (int l = 0; l < NLANE; l++) begin
      ln    = dv_q[NDS].ln[l];
      twice = {ln.rem, 1'b0};
      qr    = ln.q + MW'(twice >= {1'b0, ln.dm});
      res[l] = ln.neg ? (ln.a - coord_t'(qr[CW-1:0])) : (ln.a + coord_t'(qr[CW-1:0]));
    end
    out_d = '0;
    if (dv_q[NDS].sliced) begin
      out_d[0]                = 1'b1;
      out_d[1 + 0*CW +: CW]   = res[0];
      out_d[1 + 1*CW +: CW]   = res[1];
      out_d[1 + 2*CW +: CW]   = dv_q[NDS].cut;
      out_d[1 + 3*CW +: CW]   = res[2];
      out_d[1 + 4*CW +: CW]   = res[3];
      out_d[1 + 5*CW +: CW]   = dv_q[NDS].cut;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NST-1]) out_q <= out_d;
  end

endmodule

FILE: rtl/tzs_checker.sv
// port-level checks for the triangle z slice unit, with its bind
module tzs_checker
  import tzs_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i,
  input logic [OUT_W-1:0] m_axis_tdata_o
);

  // a stalled result holds its data
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed under stall");

  // no slice means all point fields are zero
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o == '0)
    else $error("unsliced result carries nonzero points");

  // both points sit on the same plane
  a_plane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[1+2*CW +: CW] == m_axis_tdata_o[1+5*CW +: CW])
    else $error("start z and end z differ");

  // nothing leaves the block in the cycle after reset
  a_rst: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid right after reset");

endmodule

bind triangle_z_slice_unit tzs_checker u_tzs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

FILE: tb/triangle_z_slice_unit_tb.sv
// testbench for the triangle z slice unit: random and directed triangles checked against a predictor
`timescale 1ns / 1ps

module triangle_z_slice_unit_tb
  import tzs_pkg::*;
();

  typedef struct packed {
    logic   sliced;
    coord_t sx, sy, sz, ex, ey, ez;
  } slice_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up
  logic [IN_W-1:0]  s_axis_tdata_i = '0;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  // sliced, start_x, start_y, start_z, end_x, end_y, end_z, zero pad from bit 0 up
  logic [OUT_W-1:0] m_axis_tdata_o;
  logic             cut_height_we_i = 1'b0;
  logic [CW-1:0]    cut_height_i = '0;

  triangle_z_slice_unit uut (.*);

  always #4 clk_i = ~clk_i;

  logic [IN_W-1:0] tri_pending[$];
  slice_t          slice_expected[$];
  coord_t          cut_model = '0;
  int              fail_count = 0;
  int              send_gap = 0;
  int              recv_gap = 0;
  bit              stalls_on = 1'b1;

  function automatic void add_tri(logic [IN_W-1:0] t);
    tri_pending = {tri_pending, t};
  endfunction

  function automatic void add_expected(slice_t s);
    slice_expected = {slice_expected, s};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!stalls_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // a + round((b - a) * nm / dm), rounding ties away from zero
  function automatic coord_t lerp_coord(coord_t a, coord_t b, logic [63:0] nm,
                                        logic [63:0] dm);
    logic signed [33:0] d;
    logic [33:0]        md;
    logic [127:0]       p, q, r;
    d  = 34'(b) - 34'(a);
    md = d[33] ? 34'(-d) : 34'(d);
    p  = 128'(md) * 128'(nm);
    q  = p / 128'(dm);
    r  = p % 128'(dm);
    if (r != 0 && r >= 128'(dm) - r) q = q + 1;
    return d[33] ? coord_t'(a - coord_t'(q)) : coord_t'(a + coord_t'(q));
  endfunction

  function automatic void edge_cross(coord_t ax, coord_t ay, coord_t az, coord_t bx,
                                     coord_t by, coord_t bz, coord_t cut,
                                     output coord_t px, output coord_t py,
                                     output coord_t pz);
    logic signed [33:0] n, m;
    logic [63:0]        nm, dm;
    n  = 34'(cut) - 34'(az);
    m  = 34'(bz) - 34'(az);
    nm = n[33] ? 64'(-n) : 64'(n);
    dm = m[33] ? 64'(-m) : 64'(m);
    if (dm == 0) begin
      px = ax; py = ay; pz = az;
    end else begin
      px = lerp_coord(ax, bx, nm, dm);
      py = lerp_coord(ay, by, nm, dm);
      pz = lerp_coord(az, bz, nm, dm);
    end
  endfunction

  function automatic slice_t slice_triangle(logic [IN_W-1:0] t, coord_t cut);
    slice_t res;
    coord_t vx[3], vy[3], vz[3], zmin, zmax;
    int     lo[3], hi[3], nl, nh;
    res = '0; nl = 0; nh = 0;
    for (int i = 0; i < 3; i++) begin
      vx[i] = t[(3*i)*CW +: CW];
      vy[i] = t[(3*i+1)*CW +: CW];
      vz[i] = t[(3*i+2)*CW +: CW];
    end
    zmin = vz[0]; zmax = vz[0];
    for (int i = 1; i < 3; i++) begin
      if (vz[i] < zmin) zmin = vz[i];
      if (vz[i] > zmax) zmax = vz[i];
    end
    if (!(zmin < cut) || !(cut < zmax)) return res;
    for (int i = 0; i < 3; i++) begin
      if (vz[i] <= cut) begin lo[nl] = i; nl++; end
      else begin hi[nh] = i; nh++; end
    end
    res.sliced = 1'b1;
    // two below: both edges from the lone vertex above
    if (nl == 2) begin
      edge_cross(vx[hi[0]], vy[hi[0]], vz[hi[0]], vx[lo[0]], vy[lo[0]], vz[lo[0]], cut,
                 res.sx, res.sy, res.sz);
      edge_cross(vx[hi[0]], vy[hi[0]], vz[hi[0]], vx[lo[1]], vy[lo[1]], vz[lo[1]], cut,
                 res.ex, res.ey, res.ez);
    end else begin
      edge_cross(vx[hi[0]], vy[hi[0]], vz[hi[0]], vx[lo[0]], vy[lo[0]], vz[lo[0]], cut,
                 res.sx, res.sy, res.sz);
      edge_cross(vx[hi[1]], vy[hi[1]], vz[hi[1]], vx[lo[0]], vy[lo[0]], vz[lo[0]], cut,
                 res.ex, res.ey, res.ez);
    end
    return res;
  endfunction

  // driver: one triangle per accept, random gaps between
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (s_axis_tvalid_i) begin
          add_expected(slice_triangle(s_axis_tdata_i, cut_model));
          send_gap = pick_gap();
        end
        if (send_gap > 0 || tri_pending.size() == 0) begin
          if (send_gap > 0) send_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else begin
          s_axis_tdata_i  <= tri_pending.pop_front();
          s_axis_tvalid_i <= 1'b1;
        end
      end
    end
  end

  // monitor: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    slice_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = {m_axis_tdata_o[0], m_axis_tdata_o[32:1], m_axis_tdata_o[64:33],
               m_axis_tdata_o[96:65], m_axis_tdata_o[128:97], m_axis_tdata_o[160:129],
               m_axis_tdata_o[192:161]};
        if (slice_expected.size() == 0) begin
          $error("result with no triangle outstanding");
          fail_count++;
        end else begin
          want = slice_expected.pop_front();
          if (got.sliced !== want.sliced) begin
            $error("sliced exp %0d got %0d", want.sliced, got.sliced); fail_count++;
          end
          if (got.sx !== want.sx) begin
            $error("start_x exp %0d got %0d", want.sx, got.sx); fail_count++;
          end
          if (got.sy !== want.sy) begin
            $error("start_y exp %0d got %0d", want.sy, got.sy); fail_count++;
          end
          if (got.sz !== want.sz) begin
            $error("start_z exp %0d got %0d", want.sz, got.sz); fail_count++;
          end
          if (got.ex !== want.ex) begin
            $error("end_x exp %0d got %0d", want.ex, got.ex); fail_count++;
          end
          if (got.ey !== want.ey) begin
            $error("end_y exp %0d got %0d", want.ey, got.ey); fail_count++;
          end
          if (got.ez !== want.ez) begin
            $error("end_z exp %0d got %0d", want.ez, got.ez); fail_count++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  function automatic logic [IN_W-1:0] pack_tri(coord_t v[9]);
    logic [IN_W-1:0] t;
    for (int i = 0; i < 9; i++) t[i*CW +: CW] = v[i];
    return t;
  endfunction

  // random triangle; mostly straddling the cut, some full-range noise
  function automatic logic [IN_W-1:0] rand_tri(coord_t cut);
    coord_t v[9];
    int     mode, span;
    mode = $urandom_range(0, 9);
    span = 1 << $urandom_range(0, 24);
    for (int i = 0; i < 9; i++) v[i] = $urandom;
    if (mode < 7) begin
      for (int i = 0; i < 3; i++) begin
        v[3*i+2] = cut + coord_t'($signed($urandom_range(0, 2*span)) - span);
        if (mode < 4) begin
          v[3*i]   = $signed($urandom_range(0, 2*span)) - span;
          v[3*i+1] = $signed($urandom_range(0, 2*span)) - span;
        end
      end
      if ($urandom_range(0, 7) == 0) v[3*$urandom_range(0, 2)+2] = cut;
    end
    return pack_tri(v);
  endfunction

  // wait until every queued triangle is sent and every result checked
  task automatic drain();
    do @(negedge clk_i);
    while (tri_pending.size() != 0 || s_axis_tvalid_i || slice_expected.size() != 0);
  endtask

  task automatic run_phase(coord_t cut, int n_rand);
    // register written only with the block drained
    @(posedge clk_i);
    cut_height_i    <= cut;
    cut_height_we_i <= 1'b1;
    @(posedge clk_i);
    cut_height_we_i <= 1'b0;
    cut_model = cut;
    for (int i = 0; i < n_rand; i++) add_tri(rand_tri(cut));
    drain();
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    coord_t v[9];
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, cut at reset value zero
    // two below, one above
    v = '{0, 0, -32'sh10000, 32'sh20000, 0, -32'sh10000, 0, 32'sh20000, 32'sh10000};
    add_tri(pack_tri(v));
    // one below, two above
    v = '{0, 0, 32'sh10000, 32'sh20000, 0, -32'sh30000, 0, 32'sh20000, 32'sh10000};
    add_tri(pack_tri(v));
    // cut at the lowest vertex: no slice
    v = '{1, 2, 0, 3, 4, 32'sh100, 5, 6, 32'sh200};
    add_tri(pack_tri(v));
    // cut at the highest vertex: no slice
    v = '{1, 2, 0, 3, 4, -32'sh100, 5, 6, -32'sh200};
    add_tri(pack_tri(v));
    // vertex on the plane counts as below
    v = '{7, 8, 0, 9, 10, -5, 11, 12, 5};
    add_tri(pack_tri(v));
    // extremes of every field
    v = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
          32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff};
    add_tri(pack_tri(v));
    v = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
          32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000};
    add_tri(pack_tri(v));
    // all z equal: flat, no slice
    v = '{1, 1, 0, 2, 2, 0, 3, 3, 0};
    add_tri(pack_tri(v));
    // rounding ties
    v = '{0, 1, 2, 1, 0, -2, 3, 3, -2};
    add_tri(pack_tri(v));
    stalls_on = 1'b0;
    for (int i = 0; i < 40; i++) add_tri(rand_tri(0));
    drain();
    repeat (20) @(posedge clk_i);
    stalls_on = 1'b1;

    run_phase(32'sh00018000, 150);
    run_phase(32'h80000000, 20);
    run_phase(32'h7fffffff, 20);
    run_phase(32'h80000001, 60);
    run_phase(32'h7ffffffe, 60);
    run_phase(coord_t'($urandom), 150);
    run_phase(32'sh0, 100);

    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("triangle_z_slice_unit verification clean");
    end else begin
      $display("triangle_z_slice_unit verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("triangle_z_slice_unit verification failed");
    $finish;
  end

endmodule
